/* hw/rtl/bcrtc_pkg.sv */
// ----------------------------------------------------------------------------
// bcrtc_pkg
// Shared types and constants of the bank controller with real-time clock.
// ----------------------------------------------------------------------------
package bcrtc_pkg;

  // bus operation codes
  typedef enum logic [1:0] {
    OP_REG_WRITE = 2'd0,
    OP_RAM_READ  = 2'd1,
    OP_RAM_WRITE = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  // register groups picked by address bits 14..13 (bit 15 clear)
  localparam logic [1:0] GRP_RAM_ENABLE = 2'd0;
  localparam logic [1:0] GRP_ROM_BANK   = 2'd1;
  localparam logic [1:0] GRP_RAM_BANK   = 2'd2;
  localparam logic [1:0] GRP_LATCH      = 2'd3;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_BANK_MASK = 2'd0;
  localparam logic [1:0] CFG_RAM_BANK_MASK = 2'd1;
  localparam logic [1:0] CFG_RTC_PRESENT   = 2'd2;

  // clock byte indexes
  localparam logic [2:0] RTC_SECONDS = 3'd0;
  localparam logic [2:0] RTC_MINUTES = 3'd1;
  localparam logic [2:0] RTC_HOURS   = 3'd2;
  localparam logic [2:0] RTC_DAYS    = 3'd3;
  localparam logic [2:0] RTC_FLAGS   = 3'd4;
  localparam int         RTC_BYTES   = 5;

  localparam logic [7:0] SEC_LIMIT  = 8'd60;
  localparam logic [7:0] MIN_LIMIT  = 8'd60;
  localparam logic [7:0] HOUR_LIMIT = 8'd24;
  localparam int         HALT_BIT   = 6;
  localparam int         CARRY_BIT  = 7;

  localparam logic [7:0] RTC_SEL_FIRST = 8'd8;
  localparam logic [7:0] RTC_SEL_LAST  = 8'd12;
  localparam logic [7:0] RAM_SEL_LAST  = 8'd3;
  localparam logic [7:0] LATCH_ARM     = 8'd0;
  localparam logic [7:0] LATCH_FIRE    = 8'd1;
  localparam logic [7:0] OPEN_BUS      = 8'hFF;

  // external RAM bank geometry, bank size a power of two
  localparam int RAM_BANK_BYTES  = 8192;
  localparam int RAM_OFFSET_BITS = $clog2(RAM_BANK_BYTES);

  typedef struct packed {
    logic [6:0] rom_bank_mask;
    logic [1:0] ram_bank_mask;
    logic       rtc_present;
  } cfg_t;

  typedef struct packed {
    logic       tick;
    logic       wr_en;
    logic       latch;
    logic [2:0] index;
    logic [7:0] wdata;
  } rtc_ctrl_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        ram_select;
    logic        ram_write;
    logic [14:0] ram_address;
    logic [6:0]  rom_bank;
  } rsp_t;

endpackage

/* hw/rtl/bcrtc_cfg.sv */
// ----------------------------------------------------------------------------
// bcrtc_cfg
// APB configuration registers: bank masks and clock presence.
// ----------------------------------------------------------------------------
module bcrtc_cfg
  import bcrtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr;
  logic [1:0] index;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr     = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rom_bank_mask <= 7'h7F;
      cfg.ram_bank_mask <= 2'd3;
      cfg.rtc_present   <= 1'b1;
    end else if (wr) begin
      unique case (index)
        CFG_ROM_BANK_MASK: cfg.rom_bank_mask <= pwdata[6:0];
        CFG_RAM_BANK_MASK: cfg.ram_bank_mask <= pwdata[1:0];
        CFG_RTC_PRESENT:   cfg.rtc_present   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (index)
      CFG_ROM_BANK_MASK: prdata = {25'd0, cfg.rom_bank_mask};
      CFG_RAM_BANK_MASK: prdata = {30'd0, cfg.ram_bank_mask};
      CFG_RTC_PRESENT:   prdata = {31'd0, cfg.rtc_present};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

/* hw/rtl/bcrtc_rtc.sv */
// ----------------------------------------------------------------------------
// bcrtc_rtc
// Live and latched real-time clock: tick counters, byte writes, latch copy.
// ----------------------------------------------------------------------------
module bcrtc_rtc
  import bcrtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  rtc_ctrl_t  ctrl,
  input  logic [2:0] rd_index,
  output logic [7:0] rd_byte
);

  logic [7:0] live [RTC_BYTES];
  logic [7:0] live_next [RTC_BYTES];
  logic [7:0] latched [RTC_BYTES];
  logic [7:0] sec_inc;
  logic [7:0] min_inc;
  logic [7:0] hour_inc;
  logic [8:0] days_inc;

  assign sec_inc  = live[RTC_SECONDS] + 8'd1;
  assign min_inc  = live[RTC_MINUTES] + 8'd1;
  assign hour_inc = live[RTC_HOURS] + 8'd1;
  assign days_inc = {live[RTC_FLAGS][0], live[RTC_DAYS]} + 9'd1;

  // next live clock: software write or one-second ripple
  always_comb begin
    live_next = live;
    if (ctrl.wr_en) begin
      if (ctrl.index <= RTC_FLAGS) begin
        live_next[ctrl.index] = ctrl.wdata;
      end
    end else if (ctrl.tick && !live[RTC_FLAGS][HALT_BIT]) begin
      if (sec_inc < SEC_LIMIT) begin
        live_next[RTC_SECONDS] = sec_inc;
      end else begin
        live_next[RTC_SECONDS] = 8'd0;
        if (min_inc < MIN_LIMIT) begin
          live_next[RTC_MINUTES] = min_inc;
        end else begin
          live_next[RTC_MINUTES] = 8'd0;
          if (hour_inc < HOUR_LIMIT) begin
            live_next[RTC_HOURS] = hour_inc;
          end else begin
            live_next[RTC_HOURS]    = 8'd0;
            live_next[RTC_DAYS]     = days_inc[7:0];
            live_next[RTC_FLAGS][0] = days_inc[8];
            // day counter wrap sets the sticky carry
            if (days_inc == 9'd0) begin
              live_next[RTC_FLAGS][CARRY_BIT] = 1'b1;
            end
          end
        end
      end
    end
  end

  // clock registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RTC_BYTES; i++) begin
        live[i]    <= 8'd0;
        latched[i] <= 8'd0;
      end
    end else begin
      live <= live_next;
      if (ctrl.latch) begin
        latched <= live;
      end
    end
  end

  // latched byte read, open bus beyond the flags byte
  assign rd_byte = (rd_index <= RTC_FLAGS) ? latched[rd_index] : OPEN_BUS;

endmodule

/* hw/rtl/bcrtc_bank.sv */
// ----------------------------------------------------------------------------
// bcrtc_bank
// Bank and mode registers, bus decode and result forming for one transaction.
// ----------------------------------------------------------------------------
module bcrtc_bank
  import bcrtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  cfg_t        cfg,
  input  logic [7:0]  rtc_byte,
  output logic [2:0]  rtc_rd_index,
  output rtc_ctrl_t   rtc_ctrl,
  output rsp_t        rsp
);

  op_t        op;
  logic       ram_enabled, ram_enabled_next;
  logic [6:0] rom_bank_reg, rom_bank_reg_next;
  logic [1:0] ram_bank_reg, ram_bank_reg_next;
  logic [2:0] rtc_index, rtc_index_next;
  logic       rtc_selected, rtc_selected_next;
  logic       latch_armed, latch_armed_next;
  logic [6:0] rom_pick;
  logic [7:0] rtc_offset;

  assign op           = op_t'(operation);
  assign rom_pick     = data[6:0] & cfg.rom_bank_mask;
  assign rtc_offset   = data - RTC_SEL_FIRST;
  assign rtc_rd_index = rtc_index;

  // decode and next state
  always_comb begin
    ram_enabled_next  = ram_enabled;
    rom_bank_reg_next = rom_bank_reg;
    ram_bank_reg_next = ram_bank_reg;
    rtc_index_next    = rtc_index;
    rtc_selected_next = rtc_selected;
    latch_armed_next  = latch_armed;
    rtc_ctrl          = '0;
    rtc_ctrl.index    = rtc_index;
    rtc_ctrl.wdata    = data;
    rsp.read_data     = 8'd0;
    rsp.ram_select    = 1'b0;
    rsp.ram_write     = 1'b0;
    rsp.ram_address   = 15'(({13'd0, ram_bank_reg} << RAM_OFFSET_BITS)
                          + 15'(address[RAM_OFFSET_BITS-1:0]));
    unique case (op)
      OP_REG_WRITE: begin
        if (!address[15]) begin
          unique case (address[14:13])
            GRP_RAM_ENABLE: ram_enabled_next = (data[3:0] == RAM_ENABLE_KEY);
            GRP_ROM_BANK:   rom_bank_reg_next = (rom_pick == 7'd0) ? 7'd1 : rom_pick;
            GRP_RAM_BANK: begin
              if (data <= RAM_SEL_LAST) begin
                ram_bank_reg_next = data[1:0] & cfg.ram_bank_mask;
                rtc_selected_next = 1'b0;
              end else if (cfg.rtc_present && data >= RTC_SEL_FIRST
                           && data <= RTC_SEL_LAST) begin
                rtc_selected_next = 1'b1;
                rtc_index_next    = rtc_offset[2:0];
              end
            end
            GRP_LATCH: begin
              if (ram_enabled && cfg.rtc_present) begin
                rtc_ctrl.latch   = latch_armed && (data == LATCH_FIRE);
                latch_armed_next = (data == LATCH_ARM);
              end
            end
            default: ;
          endcase
        end
      end
      OP_RAM_READ: begin
        if (!ram_enabled) begin
          rsp.read_data = OPEN_BUS;
        end else if (rtc_selected) begin
          rsp.read_data = rtc_byte;
        end else begin
          rsp.ram_select = 1'b1;
        end
      end
      OP_RAM_WRITE: begin
        if (ram_enabled) begin
          if (rtc_selected) begin
            rtc_ctrl.wr_en = 1'b1;
          end else begin
            rsp.ram_select = 1'b1;
            rsp.ram_write  = 1'b1;
          end
        end
      end
      OP_TICK: rtc_ctrl.tick = cfg.rtc_present;
      default: ;
    endcase
    // nothing moves unless the transaction advances
    if (!advance) begin
      rtc_ctrl.tick  = 1'b0;
      rtc_ctrl.wr_en = 1'b0;
      rtc_ctrl.latch = 1'b0;
    end
    rsp.rom_bank = rom_bank_reg_next;
  end

  // mode and bank registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled  <= 1'b0;
      rom_bank_reg <= 7'd1;
      ram_bank_reg <= 2'd0;
      rtc_index    <= 3'd0;
      rtc_selected <= 1'b0;
      latch_armed  <= 1'b0;
    end else if (advance) begin
      ram_enabled  <= ram_enabled_next;
      rom_bank_reg <= rom_bank_reg_next;
      ram_bank_reg <= ram_bank_reg_next;
      rtc_index    <= rtc_index_next;
      rtc_selected <= rtc_selected_next;
      latch_armed  <= latch_armed_next;
    end
  end

endmodule

/* hw/rtl/bank_controller_with_rtc.sv */
// ----------------------------------------------------------------------------
// bank_controller_with_rtc
// Cartridge bank controller with real-time clock, top level.
// ----------------------------------------------------------------------------
// One transaction (register write, RAM area read or write, or one-second tick)
// is taken on the request channel every clock cycle while the response side
// keeps up and yields one response: the request is held in an input register,
// decoded and applied to the bank and clock state in a single pass of shallow
// logic, and the result lands in a response register. A stalled response holds
// that register and the input register fills behind it, so throughput stays at
// one transaction per cycle whenever the response side takes one per cycle.
// Configuration sits on an APB port at byte addresses 0, 4 and 8 and is to be
// written only while no transaction is in flight.
module bank_controller_with_rtc
  import bcrtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [7:0]  read_data,
  output logic        ram_select,
  output logic        ram_write,
  output logic [14:0] ram_address,
  output logic [6:0]  rom_bank,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        held;
  logic [1:0]  op_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic        advance;
  cfg_t        cfg;
  rtc_ctrl_t   rtc_ctrl;
  logic [2:0]  rtc_rd_index;
  logic [7:0]  rtc_byte;
  rsp_t        rsp_comb;
  rsp_t        rsp_q;

  assign advance   = held && (!rsp_valid || rsp_ready);
  assign req_ready = !held || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req_ready) begin
      held <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op_q   <= operation;
      addr_q <= address;
      data_q <= data;
    end
  end

  bcrtc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcrtc_bank u_bank (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .operation    (op_q),
    .address      (addr_q),
    .data         (data_q),
    .cfg          (cfg),
    .rtc_byte     (rtc_byte),
    .rtc_rd_index (rtc_rd_index),
    .rtc_ctrl     (rtc_ctrl),
    .rsp          (rsp_comb)
  );

  bcrtc_rtc u_rtc (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (rtc_ctrl),
    .rd_index (rtc_rd_index),
    .rd_byte  (rtc_byte)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_q <= rsp_comb;
    end
  end

  assign read_data   = rsp_q.read_data;
  assign ram_select  = rsp_q.ram_select;
  assign ram_write   = rsp_q.ram_write;
  assign ram_address = rsp_q.ram_address;
  assign rom_bank    = rsp_q.rom_bank;

endmodule

/* hw/rtl/bcrtc_checker.sv */
// ----------------------------------------------------------------------------
// bcrtc_checker
// Port-level checks on the response channel of the bank controller.
// ----------------------------------------------------------------------------
module bcrtc_checker
  import bcrtc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [7:0]  read_data,
  input logic        ram_select,
  input logic        ram_write,
  input logic [6:0]  rom_bank
);

  // a RAM write strobe only comes with the RAM serving the transaction
  a_write_needs_select: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ram_write |-> ram_select)
    else $error("ram_write without ram_select");

  // the switchable ROM bank is never bank zero
  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rom_bank != 7'd0)
    else $error("rom_bank is zero");

  // read data is quiet while external RAM drives the bus
  a_select_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ram_select |-> read_data == 8'd0)
    else $error("read_data driven during external RAM access");

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
      && $stable(ram_select) && $stable(rom_bank))
    else $error("response changed while stalled");

endmodule

bind bank_controller_with_rtc bcrtc_checker u_checker (.*);
